// ----- rtl/adaptive_credit_window_assert.svh -----
// Assertion macros for the credit window checker.
`ifndef ADAPTIVE_CREDIT_WINDOW_ASSERT_SVH
`define ADAPTIVE_CREDIT_WINDOW_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ACW_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define ACW_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Holds in the cycle after a reset cycle.
`define ACW_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/acw_pkg.sv -----
// Shared types and constants for the adaptive credit window.
package acw_pkg;

   localparam int ACW_COUNT_WIDTH  = 64;
   localparam int ACW_WINDOW_WIDTH = 32;
   localparam int ACW_QUEUE_DEPTH  = 2;

   localparam int LEN_WIDTH     = 32;
   localparam int LTOT_WIDTH    = 63;
   localparam int CFG_WIN_WIDTH = 31;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DAT_WIDTH = 64;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_WINDOW = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_WINDOW = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LINK_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_FEEDBACK = 2'd1,
      OP_FAIL     = 2'd2,
      OP_OPEN     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_FAILED   = 3'd2,
      ST_SEND_ERR = 3'd3,
      ST_STALE    = 3'd4
   } status_type;

   typedef struct packed {
      logic [CFG_WIN_WIDTH-1:0] max_window;
      logic [CFG_WIN_WIDTH-1:0] eff_min;
      logic [LTOT_WIDTH-1:0]    link_limit;
      logic                     link_on;
      logic                     max_on;
      logic                     min_on;
   } cfg_type;

endpackage

// ----- rtl/acw_ifs.sv -----
// Request, response and register-write channel interfaces.
interface acw_req_if import acw_pkg::*; #(
   parameter int COUNT_WIDTH = ACW_COUNT_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             cmd;
   logic [LEN_WIDTH-1:0]   write_length;
   logic                   send_ok;
   logic [COUNT_WIDTH-1:0] consumed_count;
   logic [LTOT_WIDTH-1:0]  link_total;

   modport source (output valid, cmd, write_length, send_ok, consumed_count, link_total,
                   input ready);
   modport sink   (input valid, cmd, write_length, send_ok, consumed_count, link_total,
                   output ready);
endinterface

interface acw_rsp_if import acw_pkg::*; #(
   parameter int COUNT_WIDTH  = ACW_COUNT_WIDTH,
   parameter int WINDOW_WIDTH = ACW_WINDOW_WIDTH
) ();
   logic                    valid;
   logic                    ready;
   logic [2:0]              status;
   logic [WINDOW_WIDTH-1:0] window_size;
   logic                    is_full;
   logic                    wake_writers;
   logic [LEN_WIDTH-1:0]    link_add;
   logic [COUNT_WIDTH-1:0]  link_release;

   modport source (output valid, status, window_size, is_full, wake_writers, link_add,
                   link_release, input ready);
   modport sink   (input valid, status, window_size, is_full, wake_writers, link_add,
                   link_release, output ready);
endinterface

interface acw_csr_if import acw_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [CSR_DAT_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/acw_front.sv -----
// Front end: register file, request decode and queue push.
module acw_front import acw_pkg::*; #(
   parameter int COUNT_WIDTH = ACW_COUNT_WIDTH,
   parameter int ENTRY_W     = 2 + LEN_WIDTH + 1 + COUNT_WIDTH + LTOT_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   acw_req_if.sink            req,
   acw_csr_if.sink            csr,
   input  logic               q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_wdata,
   output cfg_type            cfg
);

   logic [CFG_WIN_WIDTH-1:0] max_ff;
   logic [CFG_WIN_WIDTH-1:0] min_ff;
   logic [LTOT_WIDTH-1:0]    limit_ff;
   op_type                   op;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= '0;
         limit_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_MAX_WINDOW: max_ff   <= csr.data[CFG_WIN_WIDTH-1:0];
            CSR_MIN_WINDOW: min_ff   <= csr.data[CFG_WIN_WIDTH-1:0];
            CSR_LINK_LIMIT: limit_ff <= csr.data[LTOT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.max_window = max_ff;
      cfg.max_on     = (max_ff != '0);
      cfg.eff_min    = (cfg.max_on && (min_ff > max_ff)) ? '0 : min_ff;
      cfg.link_limit = limit_ff;
      cfg.link_on    = (limit_ff != '0);
      cfg.min_on     = (cfg.eff_min != '0);
   end

   assign op = op_type'(req.cmd);

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;
   assign q_wdata   = {op, req.write_length, req.send_ok, req.consumed_count, req.link_total};

endmodule

// ----- rtl/acw_queue.sv -----
// Small FIFO between front and back end.
module acw_queue import acw_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = ACW_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output logic [DATA_W-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign rdata     = mem[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/acw_back.sv -----
// Back end: window state update and response register.
module acw_back import acw_pkg::*; #(
   parameter int COUNT_WIDTH  = ACW_COUNT_WIDTH,
   parameter int WINDOW_WIDTH = ACW_WINDOW_WIDTH,
   parameter int ENTRY_W      = 2 + LEN_WIDTH + 1 + COUNT_WIDTH + LTOT_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_valid,
   input  logic [ENTRY_W-1:0] q_rdata,
   output logic               q_pop,
   acw_rsp_if.source          rsp
);

   localparam int C = COUNT_WIDTH;
   localparam int W = WINDOW_WIDTH;
   localparam logic [W-1:0] WIN_MAX = {W{1'b1}};

   op_type               e_op;
   logic [LEN_WIDTH-1:0] e_len;
   logic                 e_ok;
   logic [C-1:0]         e_cons;
   logic [LTOT_WIDTH-1:0] e_ltot;

   logic [C-1:0] prod_ff, prod_in;
   logic [C-1:0] cons_ff, cons_in;
   logic [C-1:0] lu_ff, lu_in;
   logic [W-1:0] win_ff, win_in;
   logic         failed_ff, failed_in;

   logic         valid_ff;
   status_type   status_ff, st;
   logic [W-1:0] wsize_ff;
   logic         full_ff, full_nxt, full_cur;
   logic         wake_ff, wake, fb_live;
   logic [LEN_WIDTH-1:0] ladd_ff, ladd;
   logic [C-1:0] lrel_ff, lrel;

   logic [C-1:0]  delta, acc;
   logic [63:0]   tot;
   logic [W:0]    win2;

   function automatic logic [W-1:0] win_sat(input logic [63:0] v);
      return (v > 64'(WIN_MAX)) ? WIN_MAX : W'(v);
   endfunction

   function automatic logic reach(input logic [C-1:0] a, input logic [C-1:0] b,
                                  input logic [W-1:0] w);
      return (a >= b) && ((a - b) >= C'(w));
   endfunction

   assign {e_op, e_len, e_ok, e_cons, e_ltot} = q_rdata;

   assign q_pop = q_valid && (!valid_ff || rsp.ready);

   assign full_cur = (win_ff != '0) && reach(prod_ff, cons_ff, win_ff);
   assign delta    = e_cons - cons_ff;
   assign acc      = (delta < lu_ff) ? delta : lu_ff;
   assign tot      = (64'(e_ltot) >= 64'(acc)) ? (64'(e_ltot) - 64'(acc)) : '0;
   assign win2     = {win_ff, 1'b0};

   always_comb begin
      prod_in   = prod_ff;
      cons_in   = cons_ff;
      lu_in     = lu_ff;
      win_in    = win_ff;
      failed_in = failed_ff;
      st        = ST_OK;
      ladd      = '0;
      lrel      = '0;
      fb_live   = 1'b0;
      unique case (e_op)
         OP_OPEN: begin
            prod_in   = '0;
            cons_in   = '0;
            lu_in     = '0;
            failed_in = 1'b0;
            win_in    = (cfg.link_on && cfg.min_on) ? win_sat(64'(cfg.eff_min))
                                                    : win_sat(64'(cfg.max_window));
         end
         OP_FAIL: begin
            failed_in = 1'b1;
            if (cfg.link_on && (lu_ff != '0)) begin
               lrel  = lu_ff;
               lu_in = '0;
            end
         end
         OP_WRITE: begin
            if (failed_ff) begin
               st = ST_FAILED;
            end else if (full_cur) begin
               st = ST_FULL;
            end else if (!e_ok) begin
               st = ST_SEND_ERR;
            end else begin
               if (win_ff != '0) begin
                  prod_in = prod_ff + C'(e_len);
               end
               if (cfg.link_on) begin
                  ladd  = e_len;
                  lu_in = lu_ff + C'(e_len);
               end
            end
         end
         OP_FEEDBACK: begin
            if (failed_ff) begin
               st = ST_FAILED;
            end else if (win_ff == '0) begin
               st = ST_OK;
            end else if (cons_ff >= e_cons) begin
               st = ST_STALE;
            end else begin
               fb_live = 1'b1;
               cons_in = e_cons;
               if (cfg.link_on) begin
                  lu_in = lu_ff - acc;
                  lrel  = acc;
                  if (tot > 64'(cfg.link_limit)) begin
                     win_in = cfg.min_on ? win_sat(64'(cfg.eff_min)) : (win_ff >> 1);
                  end else if (reach(prod_ff, e_cons, win_ff) &&
                               (!cfg.max_on || (64'(win_ff) < 64'(cfg.max_window)))) begin
                     if (cfg.max_on && (64'(win2) > 64'(cfg.max_window))) begin
                        win_in = win_sat(64'(cfg.max_window));
                     end else begin
                        win_in = win_sat(64'(win2));
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      full_nxt = (win_in != '0) && reach(prod_in, cons_in, win_in);
      wake     = fb_live && full_cur && !full_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff   <= '0;
         cons_ff   <= '0;
         lu_ff     <= '0;
         win_ff    <= '0;
         failed_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (q_pop) begin
         prod_ff   <= prod_in;
         cons_ff   <= cons_in;
         lu_ff     <= lu_in;
         win_ff    <= win_in;
         failed_ff <= failed_in;
         valid_ff  <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= st;
         wsize_ff  <= win_in;
         full_ff   <= full_nxt;
         wake_ff   <= wake;
         ladd_ff   <= ladd;
         lrel_ff   <= lrel;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.window_size  = wsize_ff;
   assign rsp.is_full      = full_ff;
   assign rsp.wake_writers = wake_ff;
   assign rsp.link_add     = ladd_ff;
   assign rsp.link_release = lrel_ff;

endmodule

// ----- rtl/adaptive_credit_window.sv -----
// Adaptive credit window top level.
//
// Sender-side flow control window for one stream. Requests arrive on req_bus:
// cmd selects write, feedback, fail or open; each request beat yields exactly
// one response beat on rsp_bus with status, window size, full flag, wake flag
// and link-total adjustments. Registers max_window, min_window and link_limit
// are written on csr_bus (always ready); the user must write them only while
// the block is idle, which the block itself does not enforce. An accepted
// request beat passes through a queue entry, then the response register.
// Throughput: one beat per cycle while rsp_bus is ready, set by the back end.
// A two-entry queue separates request decode from execution; req_bus.ready
// falls only when that queue is full, which happens when rsp_bus stalls while
// request beats still arrive. A stalled response holds its payload.
// Synchronous reset clears all counters, the window, the failed flag, the
// registers and the queue; the block accepts beats in the cycle after reset.
module adaptive_credit_window import acw_pkg::*; #(
   parameter int COUNT_WIDTH  = ACW_COUNT_WIDTH,
   parameter int WINDOW_WIDTH = ACW_WINDOW_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   acw_req_if.sink     req_bus,
   acw_rsp_if.source   rsp_bus,
   acw_csr_if.sink     csr_bus
);

   localparam int ENTRY_W = 2 + LEN_WIDTH + 1 + COUNT_WIDTH + LTOT_WIDTH;

   cfg_type            cfg;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   logic [ENTRY_W-1:0] q_wdata;
   logic [ENTRY_W-1:0] q_rdata;

   acw_front #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .csr     (csr_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .cfg     (cfg)
   );

   acw_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (ACW_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .rdata     (q_rdata)
   );

   acw_back #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .WINDOW_WIDTH (WINDOW_WIDTH),
      .ENTRY_W      (ENTRY_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_rdata (q_rdata),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

// ----- rtl/acw_checker.sv -----
// Port-level checker for the adaptive credit window, with its bind.
`include "adaptive_credit_window_assert.svh"

module acw_checker import acw_pkg::*; #(
   parameter int WINDOW_WIDTH = ACW_WINDOW_WIDTH
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [2:0]              rsp_status,
   input logic [WINDOW_WIDTH-1:0] rsp_window_size,
   input logic                    rsp_is_full,
   input logic                    rsp_wake_writers
);

   `ACW_ASSERT_RST(a_rsp_idle_after_reset, !rsp_valid, "response beat right after reset")

   `ACW_ASSERT_NXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")

   `ACW_ASSERT_IMP(a_full_needs_window, rsp_valid && rsp_is_full, rsp_window_size != '0, "full with zero window")

   `ACW_ASSERT_IMP(a_wake_clean, rsp_valid && rsp_wake_writers, !rsp_is_full && (rsp_status == ST_OK), "wake on full or non-ok beat")

endmodule

bind adaptive_credit_window acw_checker #(
   .WINDOW_WIDTH (WINDOW_WIDTH)
) u_acw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_window_size  (rsp_bus.window_size),
   .rsp_is_full      (rsp_bus.is_full),
   .rsp_wake_writers (rsp_bus.wake_writers)
);
